// ===== hdl/nirt_pkg.sv =====
package nirt_pkg;

	localparam int HEADER_MARK_PULSES  = 346;
	localparam int HEADER_SPACE_PULSES = 173;
	localparam int BIT_MARK_PULSES     = 21;
	localparam int ONE_SPACE_PULSES    = 65;
	localparam int ZERO_SPACE_PULSES   = 21;

	localparam int HALF_W  = 11;
	localparam int TRAIN_W = 7;
	localparam int FRAME_W = 32;
	localparam int ADDR_W  = 16;

	localparam logic [TRAIN_W-1:0] LAST_TRAIN = TRAIN_W'(66);

	localparam logic [15:0] ADDRESS_RESET = 16'h10AF;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// a zero-length train still lasts one pulse
	function automatic logic [HALF_W-1:0] half_len(input int pulses);
		int p;
		p = (pulses < 1) ? 1 : pulses;
		return HALF_W'(2 * p);
	endfunction

	localparam logic [HALF_W-1:0] HDR_MARK_LEN  = half_len(HEADER_MARK_PULSES);
	localparam logic [HALF_W-1:0] HDR_SPACE_LEN = half_len(HEADER_SPACE_PULSES);
	localparam logic [HALF_W-1:0] BIT_MARK_LEN  = half_len(BIT_MARK_PULSES);
	localparam logic [HALF_W-1:0] ONE_SPACE_LEN = half_len(ONE_SPACE_PULSES);
	localparam logic [HALF_W-1:0] ZERO_SPACE_LEN = half_len(ZERO_SPACE_PULSES);

	typedef struct packed {
		logic       kind;
		logic [7:0] command;
		logic [7:0] check_byte;
		logic       auto_check;
	} in_item_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} out_item_t;

endpackage

// ===== hdl/nirt_if.sv =====
interface nirt_in_if;
	import nirt_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nirt_out_if;
	import nirt_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/nirt_core.sv =====
module nirt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nirt_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                          accept,
	input  nirt_pkg::in_item_t            item,
	output nirt_pkg::out_item_t           result
);
	import nirt_pkg::*;

	logic [ADDR_W-1:0]  address_q;
	logic [FRAME_W-1:0] frame_bits_q;
	logic [TRAIN_W-1:0] train_index_q;
	logic [HALF_W-1:0]  half_count_q;
	logic               sending_q;

	logic [TRAIN_W-1:0] bit_off;
	logic               cur_bit;
	logic [HALF_W-1:0]  len;
	logic [HALF_W-1:0]  half_next;
	logic               train_end;
	logic [7:0]         chk;

	// bit spaces are odd trains from 3 up; bit position 31 - k is ~k in five bits
	assign bit_off = train_index_q - TRAIN_W'(2);
	assign cur_bit = frame_bits_q[~bit_off[5:1]];

	always_comb begin
		if (train_index_q == '0) begin
			len = HDR_MARK_LEN;
		end else if (train_index_q == TRAIN_W'(1)) begin
			len = HDR_SPACE_LEN;
		end else if (!train_index_q[0]) begin
			len = BIT_MARK_LEN;
		end else begin
			len = cur_bit ? ONE_SPACE_LEN : ZERO_SPACE_LEN;
		end
	end

	assign half_next = half_count_q + HALF_W'(1);
	assign train_end = half_next >= len;
	assign chk = item.auto_check ? ~item.command : item.check_byte;

	always_comb begin
		result = '0;
		if (item.kind == KIND_START) begin
			result.busy_res = 1'b1;
			result.rejected = sending_q;
		end else if (sending_q) begin
			result.busy_res   = 1'b1;
			result.ir_level   = !train_index_q[0] && !half_count_q[0];
			result.frame_done = train_end && (train_index_q >= LAST_TRAIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q     <= ADDRESS_RESET;
			frame_bits_q  <= '0;
			train_index_q <= '0;
			half_count_q  <= '0;
			sending_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				address_q <= cfg_wdata;
			end
			if (accept) begin
				if (item.kind == KIND_START) begin
					if (!sending_q) begin
						frame_bits_q  <= {address_q, item.command, chk};
						train_index_q <= '0;
						half_count_q  <= '0;
						sending_q     <= 1'b1;
					end
				end else if (sending_q) begin
					if (train_end) begin
						half_count_q <= '0;
						if (train_index_q >= LAST_TRAIN) begin
							sending_q     <= 1'b0;
							train_index_q <= '0;
						end else begin
							train_index_q <= train_index_q + TRAIN_W'(1);
						end
					end else begin
						half_count_q <= half_next;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/nec_ir_frame_transmitter.sv =====
// NEC-style infrared frame transmitter. A start item loads the frame word
// (configured 16-bit address, command, check byte or inverted command) and
// each tick item is one half carrier period; every item yields exactly one
// result item giving the emitter level and busy, done and rejected flags.
// The block takes one item per clock cycle while input ready is high: the
// frame timing is a train counter and a half-period counter updated in the
// accepting cycle, and results go into a two-entry output register, so
// input ready depends only on whether the second entry is occupied. The
// address register may be written at any time the block holds no item in
// flight.
module nec_ir_frame_transmitter (
	input  logic                        clk,
	input  logic                        arst_n,
	nirt_in_if.sink                     req,
	nirt_out_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [nirt_pkg::ADDR_W-1:0] cfg_wdata
);
	import nirt_pkg::*;

	out_item_t result;
	out_item_t out_q;
	out_item_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      push;
	logic      pop;

	assign req.ready = !skid_valid_q;
	assign push      = req.valid && req.ready;
	assign pop       = out_valid_q && rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	nirt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (push),
		.item      (req.data),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

// ===== dv/nirt_frame_checker.sv =====
module nirt_frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	nirt_in_if                          req,
	nirt_out_if                         rsp,
	input  logic                        cfg_we,
	input  logic [nirt_pkg::ADDR_W-1:0] cfg_wdata,
	output int                          errors,
	output int                          pending
);
	import nirt_pkg::*;

	// shadow of the transmitter state
	logic [ADDR_W-1:0]  addr_word;
	logic [FRAME_W-1:0] frame_word;
	logic [TRAIN_W-1:0] train_no;
	logic [HALF_W-1:0]  half_ticks;
	logic               in_frame;

	out_item_t predicted_pins[$];

	// length of one train in half carrier periods
	function automatic int train_ticks(input logic [TRAIN_W-1:0] idx,
			input logic [FRAME_W-1:0] word);
		int pulses;
		int bitpos;
		if (idx == 0) begin
			pulses = HEADER_MARK_PULSES;
		end else if (idx == 1) begin
			pulses = HEADER_SPACE_PULSES;
		end else if (!idx[0]) begin
			pulses = BIT_MARK_PULSES;
		end else begin
			// odd trains are the spaces that carry the data, msb first
			bitpos = 31 - (((int'(idx) - 2) >> 1) & 31);
			pulses = word[bitpos] ? ONE_SPACE_PULSES : ZERO_SPACE_PULSES;
		end
		if (pulses < 1)
			pulses = 1;
		return 2 * pulses;
	endfunction

	task automatic emitter_step(input in_item_t it, output out_item_t pin);
		int len;
		pin = '0;
		if (it.kind == KIND_START) begin
			if (in_frame) begin
				pin.rejected = 1'b1;
			end else begin
				frame_word = {addr_word, it.command,
					(it.auto_check ? ~it.command : it.check_byte)};
				train_no   = '0;
				half_ticks = '0;
				in_frame   = 1'b1;
			end
			pin.busy_res = 1'b1;
		end else if (in_frame) begin
			len = train_ticks(train_no, frame_word);
			// marks are even trains, pin on in the first half of each pulse
			pin.ir_level = !train_no[0] && !half_ticks[0];
			pin.busy_res = 1'b1;
			half_ticks++;
			if (int'(half_ticks) >= len) begin
				half_ticks = '0;
				if (train_no >= LAST_TRAIN) begin
					in_frame       = 1'b0;
					train_no       = '0;
					pin.frame_done = 1'b1;
				end else begin
					train_no++;
				end
			end
		end
	endtask

	task automatic flag_error(input string why, input out_item_t want,
			input out_item_t got);
		errors++;
		if (errors <= 10)
			$display({"[%0t] %s: expected level=%b busy=%b done=%b rej=%b, ",
				"got level=%b busy=%b done=%b rej=%b"},
				$time, why, want.ir_level, want.busy_res, want.frame_done, want.rejected,
				got.ir_level, got.busy_res, got.frame_done, got.rejected);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		out_item_t next_pin;
		if (!arst_n) begin
			addr_word  = ADDRESS_RESET;
			frame_word = '0;
			train_no   = '0;
			half_ticks = '0;
			in_frame   = 1'b0;
			predicted_pins.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (predicted_pins.size() == 0) begin
					flag_error("unexpected item", '0, got);
				end else begin
					want = predicted_pins.pop_front();
					if (got.ir_level !== want.ir_level || got.busy_res !== want.busy_res ||
							got.frame_done !== want.frame_done ||
							got.rejected !== want.rejected)
						flag_error("mismatch", want, got);
				end
			end
			if (cfg_we)
				addr_word = cfg_wdata;
			if (req.valid && req.ready) begin
				emitter_step(req.data, next_pin);
				predicted_pins.push_back(next_pin);
			end
		end
		pending = predicted_pins.size();
	end

endmodule

// ===== dv/nec_ir_frame_transmitter_tb.sv =====
module nec_ir_frame_transmitter_tb;
	import nirt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;
	int                errors;
	int                pending;

	bit                tx_free;
	bit                rx_free;
	bit                hold_req;

	nirt_in_if  req_if ();
	nirt_out_if rsp_if ();

	nec_ir_frame_transmitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	nirt_frame_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len(input bit free);
		int r;
		if (free)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// entered and left at a falling edge; valid stays up for a back-to-back item
	task automatic send_item(input in_item_t it);
		int gap;
		gap = idle_len(tx_free);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= it;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_start(input logic [7:0] cmd, input logic [7:0] chk, input logic autoc);
		in_item_t it;
		it.kind       = KIND_START;
		it.command    = cmd;
		it.check_byte = chk;
		it.auto_check = autoc;
		send_item(it);
	endtask

	task automatic send_tick();
		in_item_t it;
		it.kind       = KIND_TICK;
		it.command    = 8'($urandom_range(0, 255));
		it.check_byte = 8'($urandom_range(0, 255));
		it.auto_check = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// ticks into a frame, with stray starts that must be rejected
	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 249) == 0)
				send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			send_tick();
		end
	endtask

	task automatic write_address(input logic [ADDR_W-1:0] value);
		req_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver side
	initial begin
		int stall;
		stall = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold so the output register fills and input stalls
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else begin
				rsp_if.ready <= 1'b1;
				if (!rx_free && $urandom_range(0, 3) == 0)
					stall = idle_len(1'b0);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		tx_free      = 1'b0;
		rx_free      = 1'b0;
		hold_req     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle ticks, start with auto check, starts while busy
		begin
			in_item_t it;
			it = '{kind: KIND_TICK, command: 8'hFF, check_byte: 8'hFF, auto_check: 1'b1};
			send_item(it);
			it = '{kind: KIND_TICK, command: 8'h00, check_byte: 8'h00, auto_check: 1'b0};
			send_item(it);
		end
		write_address(ADDR_W'($urandom_range(0, 65535)));
		send_start(8'h3C, 8'h00, 1'b1);
		send_start(8'hFF, 8'h00, 1'b0);
		send_start(8'hA5, 8'h5A, 1'b1);

		// header mark with the long receiver hold right at its start
		hold_req = 1'b1;
		send_ticks(240);

		// full rate on both sides
		tx_free = 1'b1;
		rx_free = 1'b1;
		send_ticks(200);

		// random gaps on the sender, steady receiver
		tx_free = 1'b0;
		send_ticks(200);

		req_if.valid <= 1'b0;
		rx_free = 1'b1;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
